### rtl/core/ctq_pkg.sv
// Shared types and constants of the capacitance triple qualifier.
package ctq_pkg;

    localparam int unsigned SAMPLE_W = 24;
    localparam int unsigned SUM_W    = 26;
    localparam int unsigned LIM_W    = 31;
    localparam int unsigned STEPS_W  = 21;
    localparam int unsigned STAGES   = 6;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_BALANCE_PCT = 2'd0;
    localparam logic [1:0] REG_RETRY_LIMIT = 2'd1;
    localparam logic [1:0] REG_MAX_STEPS   = 2'd2;

    localparam logic [6:0]  BALANCE_PCT_RST = 7'd25;
    localparam logic [3:0]  RETRY_LIMIT_RST = 4'd5;
    localparam logic [15:0] MAX_STEPS_RST   = 16'd65535;

    localparam logic [6:0]  PCT_SCALE   = 7'd100;
    localparam logic [15:0] LINEAR_END  = 16'd1000;
    localparam logic [15:0] LOG_GAIN    = 16'd1000;

    // Reciprocal multipliers: floor(x / k) = (x * MUL) >> SHIFT over the used range
    localparam logic [25:0] DIV3_MUL     = 26'd44739243;
    localparam int unsigned DIV3_SHIFT   = 27;
    localparam logic [23:0] DIV10_MUL    = 24'd13421773;
    localparam int unsigned DIV10_SHIFT  = 27;
    localparam logic [16:0] DIV1000_MUL  = 17'd67109;
    localparam int unsigned DIV1000_SHIFT = 26;

    typedef enum logic [1:0] {
        OUT_RETRY    = 2'd0,
        OUT_BALANCED = 2'd1,
        OUT_FALLBACK = 2'd2
    } outcome_t;

    // Per-stage enables; load marks an enable that takes a real item
    typedef struct packed {
        logic [STAGES-1:0] en;
        logic [STAGES-1:0] load;
    } pipe_ctrl_t;

    typedef struct packed {
        outcome_t              outcome;
        logic [SAMPLE_W-1:0]   cap;
    } cand_t;

endpackage

### rtl/core/ctq_qualify.sv
// Median, balance check and retry decision (pipeline stages one to three).
module ctq_qualify (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ctq_pkg::pipe_ctrl_t        ctrl,
    input  logic [23:0]                sample_a,
    input  logic [23:0]                sample_b,
    input  logic [23:0]                sample_c,
    input  logic [6:0]                 balance_pct,
    input  logic [3:0]                 retry_limit,
    output ctq_pkg::cand_t             cand
);
    import ctq_pkg::*;

    // stage 1: sort and sum
    logic [SAMPLE_W-1:0] lo_reg, med_reg, hi_reg;
    logic [SUM_W-1:0]    sum_reg;
    // stage 2: products and deviations
    logic [SAMPLE_W-1:0] med2_reg, avg_reg, up_reg, dn_reg;
    logic [LIM_W-1:0]    lim_reg;
    // stage 3: decision
    cand_t               cand_reg;
    logic [3:0]          retries_reg, retries_next;

    logic [SAMPLE_W-1:0] x0, x1, x2, y0, y1, z1, z2;
    logic [2*SUM_W-1:0]  avg_prod;
    logic [LIM_W-1:0]    up100, dn100;
    logic                ok;
    cand_t               cand_next;

    always_comb begin
        // three compare-swaps
        x0 = (sample_a > sample_b) ? sample_b : sample_a;
        x1 = (sample_a > sample_b) ? sample_a : sample_b;
        x2 = sample_c;
        y1 = (x1 > x2) ? x2 : x1;
        z2 = (x1 > x2) ? x1 : x2;
        y0 = (x0 > y1) ? y1 : x0;
        z1 = (x0 > y1) ? x0 : y1;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[0]) begin
            lo_reg  <= y0;
            med_reg <= z1;
            hi_reg  <= z2;
            sum_reg <= SUM_W'(sample_a) + SUM_W'(sample_b) + SUM_W'(sample_c);
        end
    end

    assign avg_prod = (2*SUM_W)'(sum_reg) * (2*SUM_W)'(DIV3_MUL);

    always_ff @(posedge aclk) begin
        if (ctrl.en[1]) begin
            med2_reg <= med_reg;
            avg_reg  <= avg_prod[DIV3_SHIFT +: SAMPLE_W];
            up_reg   <= hi_reg - med_reg;
            dn_reg   <= med_reg - lo_reg;
            lim_reg  <= LIM_W'(med_reg) * LIM_W'(balance_pct);
        end
    end

    // dist <= floor(lim / 100) is the same as dist * 100 <= lim
    assign up100 = LIM_W'(up_reg) * LIM_W'(PCT_SCALE);
    assign dn100 = LIM_W'(dn_reg) * LIM_W'(PCT_SCALE);
    assign ok    = (up100 <= lim_reg) && (dn100 <= lim_reg);

    always_comb begin
        if (ok) begin
            cand_next.outcome = OUT_BALANCED;
            cand_next.cap     = avg_reg;
            retries_next      = '0;
        end else if (retries_reg >= retry_limit) begin
            cand_next.outcome = OUT_FALLBACK;
            cand_next.cap     = med2_reg;
            retries_next      = '0;
        end else begin
            cand_next.outcome = OUT_RETRY;
            cand_next.cap     = '0;
            retries_next      = retries_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retries_reg <= '0;
        end else if (ctrl.load[2]) begin
            retries_reg <= retries_next;
        end
        if (ctrl.en[2]) begin
            cand_reg <= cand_next;
        end
    end

    assign cand = cand_reg;

endmodule

### rtl/core/ctq_compress.sv
// Step scaling, log compression and saturation (pipeline stages four to six).
module ctq_compress (
    input  logic                       aclk,
    input  ctq_pkg::pipe_ctrl_t        ctrl,
    input  ctq_pkg::cand_t             cand,
    input  logic [15:0]                max_steps,
    output ctq_pkg::outcome_t          outcome,
    output logic [23:0]                cap_value,
    output logic [15:0]                step_value
);
    import ctq_pkg::*;

    localparam int unsigned D_W = 7;

    cand_t               c4_reg, c5_reg, c6_reg;
    logic [STEPS_W-1:0]  s4_reg, s5_reg;
    logic [D_W-1:0]      d_reg;
    logic                lin_reg, inrange_reg;
    logic [15:0]         step_reg;

    logic [2*SAMPLE_W-1:0] s_prod;
    logic [32:0]           d_prod;
    logic [STEPS_W-1:0]    y;

    // 1000 + 1000 * floor(log2(d)) for d in 1..65
    function automatic logic [15:0] log_step(input logic [D_W-1:0] d);
        logic [15:0] r;
        if (d[6])      r = LINEAR_END + 16'd6 * LOG_GAIN;
        else if (d[5]) r = LINEAR_END + 16'd5 * LOG_GAIN;
        else if (d[4]) r = LINEAR_END + 16'd4 * LOG_GAIN;
        else if (d[3]) r = LINEAR_END + 16'd3 * LOG_GAIN;
        else if (d[2]) r = LINEAR_END + 16'd2 * LOG_GAIN;
        else if (d[1]) r = LINEAR_END + LOG_GAIN;
        else           r = LINEAR_END;
        return r;
    endfunction

    // stage 4: steps = cap / 10
    assign s_prod = (2*SAMPLE_W)'(cand.cap) * (2*SAMPLE_W)'(DIV10_MUL);

    always_ff @(posedge aclk) begin
        if (ctrl.en[3]) begin
            c4_reg <= cand;
            s4_reg <= s_prod[DIV10_SHIFT +: STEPS_W];
        end
    end

    // stage 5: decade index, only used when steps fit 16 bits
    assign d_prod = 33'(s4_reg[15:0]) * 33'(DIV1000_MUL);

    always_ff @(posedge aclk) begin
        if (ctrl.en[4]) begin
            c5_reg      <= c4_reg;
            s5_reg      <= s4_reg;
            d_reg       <= d_prod[DIV1000_SHIFT +: D_W];
            lin_reg     <= s4_reg <= STEPS_W'(LINEAR_END);
            inrange_reg <= s4_reg <= STEPS_W'(max_steps);
        end
    end

    // stage 6: compress and saturate
    assign y = (!lin_reg && inrange_reg) ? STEPS_W'(log_step(d_reg)) : s5_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.en[5]) begin
            c6_reg   <= c5_reg;
            step_reg <= (y > STEPS_W'(max_steps)) ? max_steps : y[15:0];
        end
    end

    assign outcome    = c6_reg.outcome;
    assign cap_value  = c6_reg.cap;
    assign step_value = step_reg;

endmodule

### rtl/core/cap_triple_qualify_log_compress_unit.sv
// Top level: configuration registers, pipeline flow control and stream ports.
//
//   channel  | direction | width | contents
//   s_axis   | in        | 72    | sample_a, sample_b, sample_c
//   m_axis   | out       | 48    | outcome, cap_value, step_value
//   cfg      | in        | 16    | balance_pct, retry_limit, max_steps
//
// Six pipeline stages; one item per cycle is sustained while the output is
// not stalled, and the multiplier and compare steps set the depth. Reset
// clears stage valid bits, the retry count and the configuration registers.
// Each stage holds only while it is full and the stage after it stalls, so
// bubbles close up and input is taken while a result waits at the output,
// as long as an empty stage remains.
module cap_triple_qualify_log_compress_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,    // sample_a, sample_b, sample_c
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // outcome, cap_value, step_value, zero fill
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import ctq_pkg::*;

    logic [6:0]         balance_pct_reg;
    logic [3:0]         retry_limit_reg;
    logic [15:0]        max_steps_reg;
    logic [STAGES-1:0]  valid_reg, valid_next, upstream;
    logic [STAGES:0]    rdy;
    pipe_ctrl_t         ctrl;
    cand_t              cand;
    outcome_t           outcome;
    logic [23:0]        cap_value;
    logic [15:0]        step_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            balance_pct_reg <= BALANCE_PCT_RST;
            retry_limit_reg <= RETRY_LIMIT_RST;
            max_steps_reg   <= MAX_STEPS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BALANCE_PCT: balance_pct_reg <= cfg_wdata[6:0];
                REG_RETRY_LIMIT: retry_limit_reg <= cfg_wdata[3:0];
                REG_MAX_STEPS:   max_steps_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // advance a stage when it is empty or the next one advances
    always_comb begin
        rdy[STAGES] = m_tready;
        for (int i = STAGES - 1; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    assign upstream  = {valid_reg[STAGES-2:0], s_tvalid};
    assign ctrl.en   = rdy[STAGES-1:0];
    assign ctrl.load = rdy[STAGES-1:0] & upstream;

    always_comb begin
        for (int i = 0; i < STAGES; i++) begin
            valid_next[i] = rdy[i] ? upstream[i] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    ctq_qualify u_qualify (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .sample_a    (s_tdata[23:0]),
        .sample_b    (s_tdata[47:24]),
        .sample_c    (s_tdata[71:48]),
        .balance_pct (balance_pct_reg),
        .retry_limit (retry_limit_reg),
        .cand        (cand)
    );

    ctq_compress u_compress (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .cand       (cand),
        .max_steps  (max_steps_reg),
        .outcome    (outcome),
        .cap_value  (cap_value),
        .step_value (step_value)
    );

    assign s_tready = rdy[0];
    assign m_tvalid = valid_reg[STAGES-1];
    assign m_tdata  = {6'b0, step_value, cap_value, outcome};

endmodule

### rtl/core/ctq_checker.sv
// Port-level checks of the qualifier top level, bound to every instance.
module ctq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    import ctq_pkg::*;

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_retry_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == OUT_RETRY) |-> (m_tdata[41:2] == '0))
        else $error("retry item carries a value");

    a_outcome_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == OUT_RETRY) || (m_tdata[1:0] == OUT_BALANCED)
                  || (m_tdata[1:0] == OUT_FALLBACK))
        else $error("bad outcome code");

    a_fill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[47:42] == '0))
        else $error("fill bits not zero");

    // the output is empty in the cycle after a reset edge
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

endmodule

bind cap_triple_qualify_log_compress_unit ctq_checker u_ctq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/cap_triple_qualify_log_compress_unit_tb.sv
// Self-checking stream testbench for the capacitance triple qualifier.
module cap_triple_qualify_log_compress_unit_tb;
    import ctq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  REG_UNUSED = 2'd3;
    localparam int unsigned PCT_DIV    = 100;
    localparam int unsigned STEP_DIV   = 10;
    localparam int unsigned LIN_LIMIT  = 1000;
    localparam int unsigned LOG_STEP   = 1000;
    localparam logic [23:0] SAMPLE_MAX = 24'hFFFFFF;
    localparam int unsigned RAND_ITEMS = 235;

    // s_tdata layout, lowest bits first: sample_a, sample_b, sample_c
    typedef struct packed {
        logic [23:0] c;
        logic [23:0] b;
        logic [23:0] a;
    } triple_t;

    // m_tdata layout, lowest bits first: outcome, cap_value, step_value, zero fill
    typedef struct packed {
        logic [5:0]  fill;
        logic [15:0] steps;
        logic [23:0] cap;
        outcome_t    outcome;
    } cap_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    // predictor state and its copy of the registers
    logic [6:0]  bal_pct = BALANCE_PCT_RST;
    logic [3:0]  retry_lim = RETRY_LIMIT_RST;
    logic [15:0] step_ceiling = MAX_STEPS_RST;
    logic [3:0]  retry_count = '0;

    triple_t     pending_triples[$];
    cap_result_t expected_results[$];
    int          err_count = 0;

    logic        idle_on = 1'b1;
    logic        hold_off_req = 1'b0;
    logic        hold_done;
    int          src_gap;
    int          sink_gap;
    int          hold_left;

    cap_triple_qualify_log_compress_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] threshold(logic [23:0] m);
        return (32'(m) * 32'(bal_pct)) / PCT_DIV;
    endfunction

    function automatic logic [23:0] abs_diff(logic [23:0] x, logic [23:0] y);
        return (x > y) ? x - y : y - x;
    endfunction

    function automatic logic [15:0] compress_steps(logic [23:0] cap);
        logic [20:0] s;
        logic [20:0] y;
        logic [10:0] decades;
        int          lg;
        s = 21'(cap / STEP_DIV);
        y = s;
        lg = 0;
        if (s > LIN_LIMIT && s <= 21'(step_ceiling)) begin
            decades = 11'(s / LIN_LIMIT);
            for (int i = 0; i < 11; i++) begin
                if (decades[i]) lg = i;
            end
            y = 21'(LIN_LIMIT + lg * LOG_STEP);
        end
        if (y > 21'(step_ceiling)) y = 21'(step_ceiling);
        return y[15:0];
    endfunction

    // Work out the result of one triple and advance the retry count.
    function automatic cap_result_t qualify_triple(triple_t t);
        logic [23:0] lo;
        logic [23:0] hi;
        logic [23:0] mid;
        logic [31:0] th;
        logic [25:0] sum;
        cap_result_t r;
        lo = (t.a < t.b) ? t.a : t.b;
        hi = (t.a < t.b) ? t.b : t.a;
        mid = (t.c < lo) ? lo : ((t.c > hi) ? hi : t.c);
        th = threshold(mid);
        r = '0;
        if (abs_diff(t.a, mid) <= th && abs_diff(t.b, mid) <= th
                && abs_diff(t.c, mid) <= th) begin
            sum = 26'(t.a) + 26'(t.b) + 26'(t.c);
            r.outcome = OUT_BALANCED;
            r.cap = 24'(sum / 3);
            retry_count = '0;
        end else if (retry_count >= retry_lim) begin
            r.outcome = OUT_FALLBACK;
            r.cap = mid;
            retry_count = '0;
        end else begin
            r.outcome = OUT_RETRY;
            retry_count = retry_count + 4'd1;
        end
        if (r.outcome != OUT_RETRY) r.steps = compress_steps(r.cap);
        return r;
    endfunction

    // Driver: offer the next pending item when the slot is free, with random gaps while idling is on.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_triples.size() > 0) begin
                s_tdata <= pending_triples.pop_front();
                s_tvalid <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 12);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_off_req && !hold_done) begin
            hold_left <= 399;
            hold_done <= 1'b1;
            m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            sink_gap <= $urandom_range(0, 11);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Predict on every accepted input item.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            expected_results.push_back(qualify_triple(triple_t'(s_tdata)));
    end

    // Check every accepted result against the oldest expectation.
    always @(posedge aclk) begin
        cap_result_t got;
        cap_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = cap_result_t'(m_tdata);
            if (expected_results.size() == 0) begin
                $error("unexpected result: outcome %0d cap_value %0d step_value %0d",
                       got.outcome, got.cap, got.steps);
                err_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.outcome !== want.outcome) begin
                    $error("outcome: expected %0d, actual %0d", want.outcome, got.outcome);
                    err_count++;
                end
                if (got.cap !== want.cap) begin
                    $error("cap_value: expected %0d, actual %0d", want.cap, got.cap);
                    err_count++;
                end
                if (got.steps !== want.steps) begin
                    $error("step_value: expected %0d, actual %0d", want.steps, got.steps);
                    err_count++;
                end
                if (got.fill !== want.fill) begin
                    $error("zero_fill: expected %0d, actual %0d", want.fill, got.fill);
                    err_count++;
                end
            end
        end
    end

    task automatic push_triple(logic [23:0] a, logic [23:0] b, logic [23:0] c);
        triple_t t;
        t.a = a;
        t.b = b;
        t.c = c;
        pending_triples.push_back(t);
    endtask

    task automatic push_shuffled(logic [23:0] x, logic [23:0] y, logic [23:0] z);
        case ($urandom_range(0, 5))
            0: push_triple(x, y, z);
            1: push_triple(x, z, y);
            2: push_triple(y, x, z);
            3: push_triple(y, z, x);
            4: push_triple(z, x, y);
            default: push_triple(z, y, x);
        endcase
    endtask

    // Median picked on a log scale so every compression range is reached.
    function automatic logic [23:0] pick_center(int unsigned bits);
        return 24'($urandom_range(0, (1 << $urandom_range(1, bits)) - 1));
    endfunction

    task automatic push_balanced();
        logic [23:0] m;
        logic [31:0] th;
        logic [31:0] up;
        logic [31:0] dn;
        m = pick_center(24);
        th = threshold(m);
        up = (th < 32'(SAMPLE_MAX - m)) ? th : 32'(SAMPLE_MAX - m);
        dn = (th < 32'(m)) ? th : 32'(m);
        push_shuffled(m, m - 24'($urandom_range(0, dn)), m + 24'($urandom_range(0, up)));
    endtask

    // Third sample just past (or right at) the allowed deviation.
    task automatic push_off_balance(int unsigned slack);
        logic [23:0] m;
        m = pick_center(22);
        push_shuffled(m, m, m + 24'(threshold(m)) + 24'($urandom_range(0, slack)));
    endtask

    task automatic fill_random(int unsigned count);
        int unsigned n;
        int unsigned run;
        @(negedge aclk);
        n = 0;
        while (n < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    push_balanced();
                    n++;
                end
                5, 6, 7: begin
                    run = $urandom_range(1, 17);
                    repeat (run) push_off_balance(255);
                    // count every item of the run
                    n += run;
                end
                8: begin
                    push_triple(24'($urandom), 24'($urandom), 24'($urandom));
                    n++;
                end
                default: begin
                    push_off_balance(1);
                    n++;
                end
            endcase
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_BALANCE_PCT: bal_pct = val[6:0];
            REG_RETRY_LIMIT: retry_lim = val[3:0];
            REG_MAX_STEPS:   step_ceiling = val;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold until every item is taken and every result is back, then let the pipe settle.
    task automatic wait_drained();
        while (pending_triples.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic set_config(logic [6:0] pct, logic [3:0] lim, logic [15:0] ceiling);
        write_reg(REG_BALANCE_PCT, 16'(pct));
        write_reg(REG_RETRY_LIMIT, 16'(lim));
        write_reg(REG_MAX_STEPS, ceiling);
        end_writes();
    endtask

    initial begin
        logic [6:0]  pct_tab[8];
        logic [3:0]  lim_tab[8];
        logic [15:0] ceil_tab[8];
        pct_tab  = '{7'd25, 7'd0, 7'd127, 7'd100, 7'd0, 7'd1, 7'd0, 7'd0};
        lim_tab  = '{4'd5, 4'd0, 4'd15, 4'd15, 4'd0, 4'd3, 4'd0, 4'd0};
        ceil_tab = '{16'd65535, 16'd0, 16'd65535, 16'd1000, 16'd0, 16'd999, 16'd0, 16'd0};
        for (int i = 4; i < 8; i += 2) begin
            pct_tab[i]  = 7'($urandom_range(0, 127));
            lim_tab[i]  = 4'($urandom_range(0, 15));
            ceil_tab[i] = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 2000))
                                                      : 16'($urandom);
        end
        pct_tab[7]  = 7'($urandom_range(0, 127));
        lim_tab[7]  = 4'($urandom_range(0, 15));
        ceil_tab[7] = 16'($urandom);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at reset settings.
        @(negedge aclk);
        push_triple(24'd0, 24'd0, 24'd0);
        push_triple(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        push_triple(24'd10000, 24'd10000, 24'd10000);
        push_triple(24'd10010, 24'd10010, 24'd10010);
        push_triple(24'd20000, 24'd20000, 24'd20000);
        push_triple(24'd655350, 24'd655350, 24'd655350);
        push_triple(24'd655360, 24'd655360, 24'd655360);
        push_triple(24'd750, 24'd1000, 24'd1250);
        // four retries, then a balanced triple clears the count
        push_triple(24'd749, 24'd1000, 24'd1250);
        push_triple(24'd0, 24'd0, SAMPLE_MAX);
        push_triple(SAMPLE_MAX, 24'd0, SAMPLE_MAX);
        push_triple(24'd1, 24'd2, 24'd3);
        push_triple(24'd5, 24'd5, 24'd6);
        push_triple(24'd100, 24'd300, 24'd200);
        push_triple(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
        push_triple(24'd123456, 24'd123456, 24'd123457);
        repeat (3) push_triple(24'd0, 24'd1, 24'd100);
        wait_drained();

        // Limit lowered below the retries already spent; the spare index is ignored.
        write_reg(REG_RETRY_LIMIT, 16'd1);
        write_reg(REG_UNUSED, 16'hFFFF);
        write_reg(REG_BALANCE_PCT, 16'd127);
        end_writes();
        @(negedge aclk);
        push_triple(24'd0, 24'd1, 24'd100);
        push_triple(24'd0, 24'd1000, 24'd2270);
        push_triple(24'd0, 24'd1000, 24'd2271);
        push_triple(24'd5, 24'd5, 24'd5);
        wait_drained();

        // Small ceiling, then no retries at all.
        write_reg(REG_MAX_STEPS, 16'd500);
        end_writes();
        @(negedge aclk);
        push_triple(24'd3000, 24'd3000, 24'd3000);
        push_triple(24'd8000, 24'd8000, 24'd8000);
        push_triple(24'd15000, 24'd15000, 24'd15000);
        wait_drained();
        write_reg(REG_RETRY_LIMIT, 16'd0);
        end_writes();
        @(negedge aclk);
        push_triple(24'd0, 24'd1, 24'd100);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            set_config(pct_tab[p], lim_tab[p], ceil_tab[p]);
            // the closing phase runs without idling on either side
            idle_on <= (p == 7) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (p == 0) hold_off_req <= 1'b1;
            fill_random(RAND_ITEMS);
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/core/ctq_pkg.sv
rtl/core/ctq_qualify.sv
rtl/core/ctq_compress.sv
rtl/core/cap_triple_qualify_log_compress_unit.sv
rtl/core/ctq_checker.sv
tb/cap_triple_qualify_log_compress_unit_tb.sv
